@@ rtl/s88fb_pkg.sv @@
// Package: shared types and constants of the feedback-bus receiver.
`default_nettype none
package s88fb_pkg;
  localparam int unsigned SensorSlots = 32;
  localparam int unsigned BusBits     = 256;
  localparam int unsigned SlotW       = $clog2(SensorSlots);
  localparam int unsigned BitW        = $clog2(BusBits);
  localparam int unsigned PosW        = $clog2(BusBits + 2);
  localparam int unsigned CntW        = $clog2(SensorSlots + 1);
  localparam int unsigned IdW         = 9;
  localparam logic [15:0] DebounceRst = 16'd200;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_CLOCK   = 3'd1,
    OP_DEFINE  = 3'd2,
    OP_FREE    = 3'd3,
    OP_FORCE   = 3'd4,
    OP_RELEASE = 3'd5,
    OP_QUERY   = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    op_e            op;
    logic [15:0]    time_ms;
    logic           data_bit;
    logic [IdW-1:0] sensor_id;
    logic           force_state;
    logic           id_ok;
  } item_t;

  typedef struct packed {
    logic           pass_bit;
    logic           ok;
    logic           found;
    logic           reported_state;
    logic           change_pending;
    logic           bit_changed;
    logic           event_valid;
    logic [IdW-1:0] event_sensor;
    logic           event_state;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/s88fb_front.sv @@
// Front end: id range check and a two-entry queue.
`default_nettype none
module s88fb_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        op_i,
  input  wire logic [15:0]       time_ms_i,
  input  wire logic              data_bit_i,
  input  wire logic [8:0]        sensor_id_i,
  input  wire logic              force_state_i,
  output logic                   q_valid_o,
  input  wire logic              q_ready_i,
  output s88fb_pkg::item_t       q_item_o
);
  s88fb_pkg::item_t mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  s88fb_pkg::item_t cls;

  // Classify: decode op and check id range.
  always_comb begin
    cls.op          = s88fb_pkg::op_e'(op_i);
    cls.time_ms     = time_ms_i;
    cls.data_bit    = data_bit_i;
    cls.sensor_id   = sensor_id_i;
    cls.force_state = force_state_i;
    cls.id_ok       = (sensor_id_i != '0) &&
                      ({23'd0, sensor_id_i} <= 32'(s88fb_pkg::BusBits));
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[wp_q] <= cls;
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wp_q <= ~wp_q;
      if (q_valid_o && q_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_o) - 2'(q_valid_o && q_ready_i);
    end
  end
endmodule
`default_nettype wire

@@ rtl/s88fb_back.sv @@
// Back end: sensor table scan, debounce, bus bitmap and result register.
`default_nettype none
module s88fb_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [15:0]      debounce_ms_i,
  input  wire logic             q_valid_i,
  output logic                  q_ready_o,
  input  wire s88fb_pkg::item_t q_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output s88fb_pkg::res_t       res_o,
  output logic                  busy_o
);
  localparam int unsigned SW = s88fb_pkg::SlotW;
  localparam int unsigned IW = s88fb_pkg::IdW;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_SCAN = 5'b00100,
    S_EXEC = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e                     st_q;
  s88fb_pkg::item_t           it_q;
  logic [SW:0]                idx_q;
  logic                       hit_q, free_q;
  logic [SW-1:0]              hslot_q, fslot_q;
  logic [s88fb_pkg::PosW-1:0] pos_q;
  logic [15:0]                load_q;
  logic [s88fb_pkg::CntW-1:0] cnt_q;
  logic [s88fb_pkg::BitW-1:0] clr_q;
  logic                       bmp_mem [s88fb_pkg::BusBits];
  logic                       bmp_rd_q;
  logic                       pos_in, bmp_we;
  logic [s88fb_pkg::SensorSlots-1:0] rep_q, raw_q, chg_q, ovr_q, pend_q;
  logic [IW-1:0]              sid_q [s88fb_pkg::SensorSlots];
  logic [15:0]                stf_q [s88fb_pkg::SensorSlots];
  s88fb_pkg::res_t            res_q;
  logic [IW-1:0]              key;
  logic [IW-1:0]              posid;

  function automatic logic [s88fb_pkg::BitW-1:0] BitIdx(input logic [s88fb_pkg::PosW-1:0] p);
    logic [s88fb_pkg::PosW-1:0] k;
    k = p - 1'b1;
    return k[s88fb_pkg::BitW-1:0];
  endfunction

  assign posid = IW'(pos_q);
  // Clock items look up the advanced bit position; others the sensor id.
  assign key = (it_q.op == s88fb_pkg::OP_CLOCK) ? posid : it_q.sensor_id;

  assign pos_in = (pos_q != '0) && (pos_q <= s88fb_pkg::PosW'(s88fb_pkg::BusBits));
  assign bmp_we = (st_q == S_EXEC) && (it_q.op == s88fb_pkg::OP_CLOCK) && pos_in;

  assign q_ready_o   = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign res_o       = res_q;
  assign busy_o      = (st_q != S_IDLE);

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i) it_q <= q_item_i;
  end

  // Bus bitmap: cleared entry by entry after reset, written by clock items, read during the scan.
  always_ff @(posedge clk_i) begin
    if (st_q == S_CLR) bmp_mem[clr_q] <= 1'b0;
    else if (bmp_we) bmp_mem[BitIdx(pos_q)] <= it_q.data_bit;
    bmp_rd_q <= bmp_mem[BitIdx(pos_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [SW-1:0]   s;
    logic [15:0]     el;
    logic            lvl, nx;
    s88fb_pkg::res_t rn;
    if (!rst_ni) begin
      st_q    <= S_CLR;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      hslot_q <= '0;
      fslot_q <= '0;
      pos_q   <= '0;
      load_q  <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
      rep_q   <= '0;
      raw_q   <= '0;
      chg_q   <= '0;
      ovr_q   <= '0;
      pend_q  <= '0;
      res_q   <= '0;
      for (int i = 0; i < int'(s88fb_pkg::SensorSlots); i++) begin
        sid_q[i] <= '0;
        stf_q[i] <= '0;
      end
    end else begin
      case (st_q)
        // One bitmap entry cleared per cycle.
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) st_q <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid_i) begin
            idx_q  <= '0;
            hit_q  <= 1'b0;
            free_q <= 1'b0;
            if (q_item_i.op == s88fb_pkg::OP_CLOCK &&
                pos_q <= s88fb_pkg::PosW'(s88fb_pkg::BusBits))
              pos_q <= pos_q + 1'b1;
            st_q <= S_SCAN;
          end
        end
        // One slot compared per cycle.
        S_SCAN: begin
          s = idx_q[SW-1:0];
          if (sid_q[s] != '0 && sid_q[s] == key && !hit_q) begin
            hit_q   <= 1'b1;
            hslot_q <= s;
          end
          if (sid_q[s] == '0 && !free_q) begin
            free_q  <= 1'b1;
            fslot_q <= s;
          end
          if (idx_q == (SW+1)'(s88fb_pkg::SensorSlots - 1)) st_q <= S_EXEC;
          idx_q <= idx_q + 1'b1;
        end
        S_EXEC: begin
          s   = hslot_q;
          rn  = '0;
          el  = load_q - stf_q[s];
          lvl = it_q.data_bit;
          case (it_q.op)
            s88fb_pkg::OP_LOAD: begin
              pos_q  <= '0;
              load_q <= it_q.time_ms;
            end
            s88fb_pkg::OP_CLOCK: begin
              rn.pass_bit = lvl;
              if (pos_in) begin
                rn.bit_changed = (bmp_rd_q != lvl);
                if (hit_q) begin
                  if (ovr_q[s]) raw_q[s] <= lvl;
                  else if (lvl == rep_q[s]) begin
                    raw_q[s] <= lvl;
                    chg_q[s] <= 1'b0;
                  end else if (lvl == raw_q[s]) begin
                    if (chg_q[s] && el >= debounce_ms_i) begin
                      chg_q[s]  <= 1'b0;
                      rep_q[s]  <= lvl;
                      stf_q[s]  <= '0;
                      pend_q[s] <= 1'b1;
                      rn.event_valid  = 1'b1;
                      rn.event_sensor = sid_q[s];
                      rn.event_state  = lvl;
                    end
                  end else begin
                    raw_q[s] <= lvl;
                    chg_q[s] <= 1'b1;
                    stf_q[s] <= load_q;
                  end
                end
              end
            end
            s88fb_pkg::OP_DEFINE: begin
              if (it_q.id_ok) begin
                if (hit_q) rn.ok = 1'b1;
                else if (cnt_q < s88fb_pkg::CntW'(s88fb_pkg::SensorSlots) && free_q) begin
                  sid_q[fslot_q]  <= it_q.sensor_id;
                  rep_q[fslot_q]  <= 1'b0;
                  raw_q[fslot_q]  <= 1'b0;
                  chg_q[fslot_q]  <= 1'b0;
                  ovr_q[fslot_q]  <= 1'b0;
                  stf_q[fslot_q]  <= '0;
                  pend_q[fslot_q] <= 1'b0;
                  cnt_q <= cnt_q + 1'b1;
                  rn.ok = 1'b1;
                end
              end
            end
            s88fb_pkg::OP_FREE: begin
              if (it_q.id_ok && hit_q) begin
                sid_q[s]  <= '0;
                rep_q[s]  <= 1'b0;
                raw_q[s]  <= 1'b0;
                chg_q[s]  <= 1'b0;
                ovr_q[s]  <= 1'b0;
                stf_q[s]  <= '0;
                pend_q[s] <= 1'b0;
                if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
                rn.ok = 1'b1;
              end
            end
            s88fb_pkg::OP_FORCE, s88fb_pkg::OP_RELEASE: begin
              if (it_q.id_ok && hit_q) begin
                nx = (it_q.op == s88fb_pkg::OP_FORCE) ? it_q.force_state : raw_q[s];
                rn.ok = 1'b1;
                ovr_q[s] <= (it_q.op == s88fb_pkg::OP_FORCE);
                rep_q[s] <= nx;
                if (rep_q[s] != nx) begin
                  pend_q[s] <= 1'b1;
                  rn.event_valid  = 1'b1;
                  rn.event_sensor = sid_q[s];
                  rn.event_state  = nx;
                end
              end
            end
            s88fb_pkg::OP_QUERY: begin
              if (it_q.id_ok && hit_q) begin
                rn.ok             = 1'b1;
                rn.found          = 1'b1;
                rn.reported_state = rep_q[s];
                rn.change_pending = pend_q[s];
                pend_q[s] <= 1'b0;
              end
            end
            default: ;
          endcase
          res_q <= rn;
          st_q  <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/s88_feedback_receiver_debounce_unit.sv @@
// Top level: feedback-bus receiver with a debounced sensor table.
// Each item passes through the load, table scan, exec and result-out states in order.
// The back end takes a new item only once the last result is taken; the scan compares one slot per cycle.
// A two-entry queue lets inputs be taken while the back end works.
// Reset (asynchronous, active low) clears table, counters; debounce_ms = 200.
// After reset all 256 bus bitmap entries are cleared before the back end takes the first item.
`default_nettype none
module s88_feedback_receiver_debounce_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [15:0] time_ms_i,
  input  wire logic        data_bit_i,
  input  wire logic [8:0]  sensor_id_i,
  input  wire logic        force_state_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             pass_bit_o,
  output logic             ok_o,
  output logic             found_o,
  output logic             reported_state_o,
  output logic             change_pending_o,
  output logic             bit_changed_o,
  output logic             event_valid_o,
  output logic [8:0]       event_sensor_o,
  output logic             event_state_o
);
  logic             q_valid, q_ready, busy;
  s88fb_pkg::item_t q_item;
  s88fb_pkg::res_t  res;
  logic [15:0]      deb_q;

  // Debounce time register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) deb_q <= s88fb_pkg::DebounceRst;
    else if (cfg_valid_i) deb_q <= cfg_data_i;
  end

  s88fb_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .time_ms_i, .data_bit_i,
    .sensor_id_i, .force_state_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  s88fb_back u_back (
    .clk_i, .rst_ni, .debounce_ms_i(deb_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o, .out_ready_i, .res_o(res), .busy_o(busy)
  );

  assign pass_bit_o       = res.pass_bit;
  assign ok_o             = res.ok;
  assign found_o          = res.found;
  assign reported_state_o = res.reported_state;
  assign change_pending_o = res.change_pending;
  assign bit_changed_o    = res.bit_changed;
  assign event_valid_o    = res.event_valid;
  assign event_sensor_o   = res.event_sensor;
  assign event_state_o    = res.event_state;

  // A result only appears while the back end is busy.
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result without work");
  // Events only name a real sensor.
  a_evt_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_valid_o) |-> (event_sensor_o != 9'd0))
    else $error("event on empty slot");
  // Query-only fields stay clear unless found.
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> !change_pending_o && !reported_state_o)
    else $error("query fields without hit");
endmodule
`default_nettype wire

@@ tb/sv/tb_s88_feedback_receiver_debounce_unit.sv @@
// Testbench for the feedback-bus receiver: directed table, then random bus frames.
`timescale 1ns / 1ps
module tb_s88_feedback_receiver_debounce_unit;
  localparam int unsigned BusBits     = s88fb_pkg::BusBits;
  localparam int unsigned SensorSlots = s88fb_pkg::SensorSlots;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i = '0;
  logic [15:0] time_ms_i = '0;
  logic        data_bit_i = 1'b0;
  logic [8:0]  sensor_id_i = '0;
  logic        force_state_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        pass_bit_o, ok_o, found_o, reported_state_o, change_pending_o;
  logic        bit_changed_o, event_valid_o, event_state_o;
  logic [8:0]  event_sensor_o;
  s88fb_pkg::res_t got;

  s88_feedback_receiver_debounce_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .op_i, .time_ms_i, .data_bit_i, .sensor_id_i,
    .force_state_i, .out_valid_o, .out_ready_i,
    .pass_bit_o, .ok_o, .found_o, .reported_state_o, .change_pending_o,
    .bit_changed_o, .event_valid_o, .event_sensor_o, .event_state_o
  );

  assign got = {pass_bit_o, ok_o, found_o, reported_state_o, change_pending_o,
                bit_changed_o, event_valid_o, event_sensor_o, event_state_o};

  always #5 clk_i = ~clk_i;

  // Predicted sensor table and bus state
  logic        bus_map [BusBits];
  int unsigned bus_pos;
  logic [15:0] frame_time;
  logic [8:0]  tab_id [SensorSlots];
  logic        tab_rep [SensorSlots];
  logic        tab_raw [SensorSlots];
  logic        tab_chg [SensorSlots];
  logic        tab_ovr [SensorSlots];
  logic [15:0] tab_from [SensorSlots];
  logic        tab_pend [SensorSlots];
  int unsigned n_defined;
  logic [15:0] debounce_ms;

  s88fb_pkg::res_t expected_results [$];
  int unsigned n_mismatch = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  function automatic int find_sensor(logic [8:0] id);
    for (int i = 0; i < SensorSlots; i++)
      if (tab_id[i] != 0 && tab_id[i] == id) return i;
    return SensorSlots;
  endfunction

  function automatic void clear_sensor(int i);
    tab_id[i] = '0; tab_rep[i] = 0; tab_raw[i] = 0; tab_chg[i] = 0;
    tab_ovr[i] = 0; tab_from[i] = '0; tab_pend[i] = 0;
  endfunction

  function automatic void raise_change(int s, ref s88fb_pkg::res_t r);
    tab_pend[s] = 1;
    r.event_valid = 1;
    r.event_sensor = tab_id[s];
    r.event_state = tab_rep[s];
  endfunction

  function automatic void predict_reset();
    for (int i = 0; i < BusBits; i++) bus_map[i] = 0;
    for (int i = 0; i < SensorSlots; i++) clear_sensor(i);
    bus_pos = 0; frame_time = '0; n_defined = 0; debounce_ms = s88fb_pkg::DebounceRst;
  endfunction

  // Debounced level of one sensor on a clock bit
  function automatic void settle_level(int s, logic lvl, ref s88fb_pkg::res_t r);
    logic [15:0] elapsed;
    elapsed = frame_time - tab_from[s];
    if (tab_ovr[s]) begin
      tab_raw[s] = lvl;
    end else if (lvl == tab_rep[s]) begin
      tab_raw[s] = lvl;
      tab_chg[s] = 0;
    end else if (lvl == tab_raw[s]) begin
      if (tab_chg[s] && elapsed >= debounce_ms) begin
        tab_chg[s] = 0;
        tab_rep[s] = lvl;
        tab_from[s] = '0;
        raise_change(s, r);
      end
    end else begin
      tab_raw[s] = lvl;
      tab_chg[s] = 1;
      tab_from[s] = frame_time;
    end
  endfunction

  function automatic s88fb_pkg::res_t predict_result(s88fb_pkg::op_e op, logic [15:0] t,
                                                     logic b, logic [8:0] id, logic fs);
    s88fb_pkg::res_t r;
    int   s;
    bit   idv;
    logic nxt;
    r = '0;
    idv = (id >= 1 && id <= BusBits);
    s = find_sensor(id);
    case (op)
      s88fb_pkg::OP_LOAD: begin
        bus_pos = 0;
        frame_time = t;
      end
      s88fb_pkg::OP_CLOCK: begin
        r.pass_bit = b;
        if (bus_pos <= BusBits) bus_pos++;
        if (bus_pos >= 1 && bus_pos <= BusBits) begin
          r.bit_changed = (bus_map[bus_pos-1] != b);
          bus_map[bus_pos-1] = b;
          s = find_sensor(bus_pos[8:0]);
          if (s < SensorSlots) settle_level(s, b, r);
        end
      end
      s88fb_pkg::OP_DEFINE: begin
        if (idv && s < SensorSlots) r.ok = 1;
        else if (idv && n_defined < SensorSlots) begin
          for (int i = 0; i < SensorSlots; i++)
            if (tab_id[i] == 0) begin
              clear_sensor(i);
              tab_id[i] = id;
              n_defined++;
              r.ok = 1;
              break;
            end
        end
      end
      s88fb_pkg::OP_FREE: begin
        if (idv && s < SensorSlots) begin
          clear_sensor(s);
          if (n_defined > 0) n_defined--;
          r.ok = 1;
        end
      end
      s88fb_pkg::OP_FORCE, s88fb_pkg::OP_RELEASE: begin
        if (idv && s < SensorSlots) begin
          r.ok = 1;
          nxt = (op == s88fb_pkg::OP_FORCE) ? fs : tab_raw[s];
          tab_ovr[s] = (op == s88fb_pkg::OP_FORCE);
          if (tab_rep[s] != nxt) begin
            tab_rep[s] = nxt;
            raise_change(s, r);
          end
        end
      end
      s88fb_pkg::OP_QUERY: begin
        if (idv && s < SensorSlots) begin
          r.ok = 1;
          r.found = 1;
          r.reported_state = tab_rep[s];
          r.change_pending = tab_pend[s];
          tab_pend[s] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one item, wait for its transfer, record the expectation
  task automatic send_item(s88fb_pkg::op_e op, logic [15:0] t, logic b, logic [8:0] id,
                           logic fs, bit typed = 0, s88fb_pkg::res_t typed_res = '0);
    int   gap;
    s88fb_pkg::res_t r;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op; time_ms_i <= t; data_bit_i <= b; sensor_id_i <= id; force_state_i <= fs;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    r = predict_result(op, t, b, id, fs);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_debounce(logic [15:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    debounce_ms = v;
  endtask

  // Result side: random stalls, one long hold on request
  initial begin
    int w;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        w = quiet ? 0 : $urandom_range(0, 6);
        if (w > 0) begin
          out_ready_i <= 1'b0;
          repeat (w) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        s88fb_pkg::res_t e;
        e = expected_results.pop_front();
        if (got !== e) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("result differs: expected %p, got %p", e, got);
        end
      end
      @(posedge clk_i);
    end
  end

  typedef struct {
    s88fb_pkg::op_e op;
    logic [15:0]    t;
    logic           b;
    logic [8:0]     id;
    logic           fs;
    bit             typed;
  } step_t;

  // Stimulus
  initial begin
    step_t       dir [$];
    logic        level [BusBits];
    logic [15:0] clock_ms;
    logic [15:0] settings [4];
    int          nclk;
    int          sel;
    logic [8:0]  pick;

    predict_reset();
    for (int i = 0; i < BusBits; i++) level[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rows marked typed expect an all-zero result
    dir = '{
      '{s88fb_pkg::OP_QUERY, 16'd0, 1'b0, 9'd1, 1'b0, 1},
      '{s88fb_pkg::OP_DEFINE, 16'd0, 1'b0, 9'd0, 1'b0, 1},
      '{s88fb_pkg::OP_DEFINE, 16'd0, 1'b0, 9'd511, 1'b0, 1},
      '{s88fb_pkg::OP_FORCE, 16'd0, 1'b1, 9'd257, 1'b1, 1},
      '{s88fb_pkg::OP_FREE, 16'd0, 1'b0, 9'd5, 1'b0, 1},
      '{s88fb_pkg::OP_NONE, 16'hffff, 1'b1, 9'd511, 1'b1, 1},
      '{s88fb_pkg::OP_DEFINE, 16'd0, 1'b0, 9'd1, 1'b0, 0},
      '{s88fb_pkg::OP_DEFINE, 16'd0, 1'b0, 9'd256, 1'b0, 0},
      '{s88fb_pkg::OP_DEFINE, 16'd0, 1'b0, 9'd1, 1'b0, 0},
      '{s88fb_pkg::OP_LOAD, 16'hffff, 1'b0, 9'd0, 1'b0, 0},
      '{s88fb_pkg::OP_CLOCK, 16'd0, 1'b1, 9'd0, 1'b0, 0},
      '{s88fb_pkg::OP_QUERY, 16'd0, 1'b0, 9'd1, 1'b0, 0},
      '{s88fb_pkg::OP_LOAD, 16'd198, 1'b0, 9'd0, 1'b0, 0},
      '{s88fb_pkg::OP_CLOCK, 16'd0, 1'b1, 9'd0, 1'b0, 0},
      '{s88fb_pkg::OP_LOAD, 16'd199, 1'b0, 9'd0, 1'b0, 0},
      '{s88fb_pkg::OP_CLOCK, 16'd0, 1'b1, 9'd0, 1'b0, 0},
      '{s88fb_pkg::OP_QUERY, 16'd0, 1'b0, 9'd1, 1'b0, 0},
      '{s88fb_pkg::OP_QUERY, 16'd0, 1'b0, 9'd1, 1'b0, 0},
      '{s88fb_pkg::OP_FORCE, 16'd0, 1'b0, 9'd1, 1'b0, 0},
      '{s88fb_pkg::OP_CLOCK, 16'd0, 1'b0, 9'd0, 1'b0, 0},
      '{s88fb_pkg::OP_RELEASE, 16'd0, 1'b0, 9'd1, 1'b0, 0},
      '{s88fb_pkg::OP_FORCE, 16'd0, 1'b0, 9'd256, 1'b1, 0},
      '{s88fb_pkg::OP_FREE, 16'd0, 1'b0, 9'd256, 1'b0, 0},
      '{s88fb_pkg::OP_QUERY, 16'd0, 1'b0, 9'd256, 1'b0, 0}
    };
    foreach (dir[k])
      send_item(dir[k].op, dir[k].t, dir[k].b, dir[k].id, dir[k].fs, dir[k].typed, '0);

    // Random frames under several debounce settings
    settings = '{16'd0, 16'hffff, 16'($urandom_range(1, 60)), 16'd200};
    clock_ms = 16'($urandom);
    foreach (settings[p]) begin
      write_debounce(settings[p]);
      quiet = (p == 1);
      if (p == 2) hold_req = 1'b1;
      repeat (11) begin
        // frame: load, bits, a few table commands
        if ($urandom_range(0, 9) == 0) clock_ms = 16'($urandom);
        else clock_ms += 16'($urandom_range(0, 120));
        send_item(s88fb_pkg::OP_LOAD, clock_ms, 1'($urandom), 9'($urandom), 1'($urandom));
        nclk = ($urandom_range(0, 15) == 0) ? 258 : $urandom_range(1, 48);
        for (int c = 0; c < nclk; c++) begin
          if (c < BusBits && $urandom_range(0, 7) == 0) level[c] = ~level[c];
          send_item(s88fb_pkg::OP_CLOCK, 16'($urandom),
                    (c < BusBits) ? level[c] : 1'($urandom), 9'($urandom), 1'($urandom));
        end
        repeat ($urandom_range(0, 6)) begin
          sel = $urandom_range(0, 9);
          pick = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(1, 44));
          case (sel)
            0, 1, 2: send_item(s88fb_pkg::OP_DEFINE, 16'($urandom), 1'($urandom), pick,
                               1'($urandom));
            3:       send_item(s88fb_pkg::OP_FREE, 16'($urandom), 1'($urandom), pick,
                               1'($urandom));
            4:       send_item(s88fb_pkg::OP_FORCE, 16'($urandom), 1'($urandom), pick,
                               1'($urandom));
            5:       send_item(s88fb_pkg::OP_RELEASE, 16'($urandom), 1'($urandom), pick,
                               1'($urandom));
            6:       send_item(s88fb_pkg::OP_NONE, 16'($urandom), 1'($urandom), pick,
                               1'($urandom));
            default: send_item(s88fb_pkg::OP_QUERY, 16'($urandom), 1'($urandom), pick,
                               1'($urandom));
          endcase
        end
      end
    end

    drain();
    if (n_mismatch == 0 && expected_results.size() == 0)
      $display("s88_feedback_receiver_debounce_unit: match");
    else
      $display("s88_feedback_receiver_debounce_unit: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("s88_feedback_receiver_debounce_unit: mismatch");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/s88fb_pkg.sv
rtl/s88fb_front.sv
rtl/s88fb_back.sv
rtl/s88_feedback_receiver_debounce_unit.sv
tb/sv/tb_s88_feedback_receiver_debounce_unit.sv
